@@ rtl/skt_pkg.sv @@
// ----------------------------------------------------------------------------
// skt_pkg: shared types and constants of the sorted key table unit
// Table geometry, field widths, operation codes and the RAM request bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package skt_pkg;

   // table geometry
   localparam int unsigned CAPACITY = 4096;
   localparam int unsigned ADDR_W   = $clog2(CAPACITY);

   // field widths
   localparam int unsigned KEY_W    = 64;
   localparam int unsigned FUNC_W   = 2;
   localparam int unsigned COUNT_W  = 13;

   // full-table count at the count width
   localparam logic [COUNT_W-1:0] CAPACITY_COUNT = COUNT_W'(CAPACITY);

   // operation codes; the unused code behaves as a lookup
   localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd2;

   // one cycle of accesses from the controller to the key RAM
   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [KEY_W-1:0]  wr_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } ram_req_type;

endpackage

`default_nettype wire

@@ rtl/skt_if.sv @@
// ----------------------------------------------------------------------------
// skt_if: request and response channels of the sorted key table unit
// Valid/ready channels; a transaction moves at a clock edge with both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface skt_req_if;
   logic                             valid;
   logic                             ready;
   logic [skt_pkg::FUNC_W-1:0]       func;
   logic signed [skt_pkg::KEY_W-1:0] key;

   modport source (output valid, output func, output key, input ready);
   modport sink   (input valid, input func, input key, output ready);
endinterface

interface skt_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         found;
   logic [skt_pkg::COUNT_W-1:0]  position;
   logic [skt_pkg::COUNT_W-1:0]  count;
   logic                         refused;

   modport source (output valid, output found, output position, output count,
                   output refused, input ready);
   modport sink   (input valid, input found, input position, input count,
                   input refused, output ready);
endinterface

`default_nettype wire

@@ rtl/skt_key_ram.sv @@
// ----------------------------------------------------------------------------
// skt_key_ram: key storage
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module skt_key_ram (
   input  wire                          clock,
   input  skt_pkg::ram_req_type         ram_req,
   output logic [skt_pkg::KEY_W-1:0]    rd_data
);

   logic [skt_pkg::KEY_W-1:0] mem [skt_pkg::CAPACITY];

   // write port
   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         mem[ram_req.wr_addr] <= ram_req.wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (ram_req.rd_en) begin
         rd_data <= mem[ram_req.rd_addr];
      end
   end

endmodule

`default_nettype wire

@@ rtl/skt_ctrl.sv @@
// ----------------------------------------------------------------------------
// skt_ctrl: search and insert sequencer
// Runs the binary search one probe per cycle against the key RAM, shifts
// larger entries up one slot per cycle on insert, and holds the response.
// ----------------------------------------------------------------------------
`default_nettype none

module skt_ctrl (
   input  wire                          clock,
   input  wire                          reset,
   skt_req_if.sink                      req,
   skt_rsp_if.source                    rsp,
   output skt_pkg::ram_req_type         ram_req,
   input  wire [skt_pkg::KEY_W-1:0]     rd_data
);

   localparam int unsigned AW = skt_pkg::ADDR_W;
   localparam int unsigned CW = skt_pkg::COUNT_W;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SEARCH = 2'd1;
   localparam logic [1:0] ST_SHIFT  = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0]                 state_ff, state_in;
   logic [skt_pkg::FUNC_W-1:0] func_ff, func_in;
   logic [skt_pkg::KEY_W-1:0]  key_ff, key_in;
   logic [CW-1:0]              lo_ff, lo_in;
   logic [CW-1:0]              hi_ff, hi_in;
   logic [CW-1:0]              idx_ff, idx_in;
   logic [CW-1:0]              pos_ff, pos_in;
   logic [CW-1:0]              count_ff, count_in;
   logic [AW-1:0]              rd_addr_ff, rd_addr_in;
   logic                       rd_pend_ff, rd_pend_in;
   logic                       found_ff, found_in;
   logic                       refused_ff, refused_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_found_ff, rsp_found_in;
   logic                       rsp_refused_ff, rsp_refused_in;
   logic [CW-1:0]              rsp_pos_ff, rsp_pos_in;
   logic [CW-1:0]              rsp_count_ff, rsp_count_in;

   // next-state logic
   always_comb begin
      logic          lt_v;
      logic          found_v;
      logic [CW-1:0] lo_v;
      logic [CW-1:0] hi_v;
      logic [CW-1:0] probe_v;
      logic [CW-1:0] idx_v;
      logic [CW:0]   sum_v;

      state_in       = state_ff;
      func_in        = func_ff;
      key_in         = key_ff;
      lo_in          = lo_ff;
      hi_in          = hi_ff;
      idx_in         = idx_ff;
      pos_in         = pos_ff;
      count_in       = count_ff;
      rd_addr_in     = rd_addr_ff;
      rd_pend_in     = rd_pend_ff;
      found_in       = found_ff;
      refused_in     = refused_ff;
      rsp_found_in   = rsp_found_ff;
      rsp_refused_in = rsp_refused_ff;
      rsp_pos_in     = rsp_pos_ff;
      rsp_count_in   = rsp_count_ff;

      ram_req.wr_en   = 1'b0;
      ram_req.wr_addr = rd_addr_ff;
      ram_req.wr_data = rd_data;
      ram_req.rd_en   = 1'b0;
      ram_req.rd_addr = rd_addr_ff;

      lt_v    = 1'b0;
      found_v = found_ff;
      lo_v    = lo_ff;
      hi_v    = hi_ff;
      probe_v = CW'(rd_addr_ff);
      idx_v   = idx_ff;
      sum_v   = '0;

      // drop the response once taken
      rsp_valid_in = rsp_valid_ff && !rsp.ready;

      case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               func_in    = req.func;
               key_in     = req.key;
               found_in   = 1'b0;
               refused_in = 1'b0;
               pos_in     = '0;
               if (req.func == skt_pkg::FUNC_CLEAR) begin
                  count_in = '0;
                  state_in = ST_FINISH;
               end else begin
                  lo_in      = '0;
                  hi_in      = count_ff;
                  rd_pend_in = 1'b0;
                  state_in   = ST_SEARCH;
               end
            end
         end

         ST_SEARCH: begin
            // narrow the bounds with the probe that just came back
            if (rd_pend_ff) begin
               lt_v = $signed(rd_data) < $signed(key_ff);
               if (lt_v) begin
                  lo_v = probe_v + CW'(1);
               end else begin
                  hi_v    = probe_v;
                  found_v = (rd_data == key_ff);
               end
            end
            lo_in    = lo_v;
            hi_in    = hi_v;
            found_in = found_v;
            if (lo_v < hi_v) begin
               // issue the next probe at the midpoint
               sum_v           = {1'b0, lo_v} + {1'b0, hi_v};
               ram_req.rd_en   = 1'b1;
               ram_req.rd_addr = sum_v[AW:1];
               rd_addr_in      = sum_v[AW:1];
               rd_pend_in      = 1'b1;
            end else begin
               rd_pend_in = 1'b0;
               // 1-based index on a hit, insertion point otherwise
               pos_in     = found_v ? lo_v + CW'(1) : lo_v;
               if (func_ff == skt_pkg::FUNC_INSERT && !found_v) begin
                  if (count_ff >= skt_pkg::CAPACITY_COUNT) begin
                     refused_in = 1'b1;
                     state_in   = ST_FINISH;
                  end else begin
                     idx_in   = count_ff;
                     state_in = ST_SHIFT;
                  end
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end

         ST_SHIFT: begin
            // move the entry read last cycle up one slot
            if (rd_pend_ff) begin
               ram_req.wr_en   = 1'b1;
               ram_req.wr_addr = rd_addr_ff + AW'(1);
               ram_req.wr_data = rd_data;
            end
            if (idx_ff > pos_ff) begin
               idx_v           = idx_ff - CW'(1);
               ram_req.rd_en   = 1'b1;
               ram_req.rd_addr = idx_v[AW-1:0];
               rd_addr_in      = idx_v[AW-1:0];
               idx_in          = idx_v;
               rd_pend_in      = 1'b1;
            end else begin
               rd_pend_in = 1'b0;
               if (!rd_pend_ff) begin
                  // place the new key in the freed slot
                  ram_req.wr_en   = 1'b1;
                  ram_req.wr_addr = pos_ff[AW-1:0];
                  ram_req.wr_data = key_ff;
                  count_in        = count_ff + CW'(1);
                  state_in        = ST_FINISH;
               end
            end
         end

         ST_FINISH: begin
            // load the response register once it is free
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_found_in   = found_ff;
               rsp_refused_in = refused_ff;
               rsp_pos_in     = pos_ff;
               rsp_count_in   = count_ff;
               state_in       = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_pend_ff   <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_pend_ff   <= rd_pend_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working and payload registers
   always_ff @(posedge clock) begin
      func_ff        <= func_in;
      key_ff         <= key_in;
      lo_ff          <= lo_in;
      hi_ff          <= hi_in;
      idx_ff         <= idx_in;
      pos_ff         <= pos_in;
      rd_addr_ff     <= rd_addr_in;
      found_ff       <= found_in;
      refused_ff     <= refused_in;
      rsp_found_ff   <= rsp_found_in;
      rsp_refused_ff <= rsp_refused_in;
      rsp_pos_ff     <= rsp_pos_in;
      rsp_count_ff   <= rsp_count_in;
   end

   assign req.ready    = (state_ff == ST_IDLE);
   assign rsp.valid    = rsp_valid_ff;
   assign rsp.found    = rsp_found_ff;
   assign rsp.refused  = rsp_refused_ff;
   assign rsp.position = rsp_pos_ff;
   assign rsp.count    = rsp_count_ff;

   // table never grows past capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= skt_pkg::CAPACITY_COUNT)
      else $error("entry count above capacity");

   // search bounds stay ordered and inside the stored entries
   a_search_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEARCH) |-> (lo_ff <= hi_ff && hi_ff <= count_ff))
      else $error("search bounds out of order");

   // a shift only starts with room for one more key
   a_shift_room: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHIFT) |-> (count_ff < skt_pkg::CAPACITY_COUNT))
      else $error("shift into a full table");

   // a refusal is reported only against a full table
   a_refused_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_refused_ff) |->
         (rsp_count_ff == skt_pkg::CAPACITY_COUNT && !rsp_found_ff))
      else $error("refusal with room left");

   // a hit reports a 1-based index within the stored entries
   a_found_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_found_ff) |->
         (rsp_pos_ff != '0 && rsp_pos_ff <= rsp_count_ff))
      else $error("found index out of range");

endmodule

`default_nettype wire

@@ rtl/sorted_key_table_search_insert_unit.sv @@
// Clear goes straight to the response; lookup and insert first run a binary
//   search of P probes, at most ceil(log2(count+1)), 13 for a full table.
// Insert of a new key then shifts larger entries up one slot per cycle through
//   the key RAM, or writes the key without a shift when it goes at the end.
// Flow: one transaction at a time, accepted when idle, one probe a cycle.
// Reset clears the entry count and control; RAM contents are not cleared.
// ----------------------------------------------------------------------------
// sorted_key_table_search_insert_unit: sorted key table with search and insert
// Holds ascending signed keys in one RAM; clears, inserts and looks up keys.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_key_table_search_insert_unit (
   input  wire        clock,
   input  wire        reset,
   skt_req_if.sink    req,
   skt_rsp_if.source  rsp
);

   skt_pkg::ram_req_type      ram_req;
   logic [skt_pkg::KEY_W-1:0] rd_data;

   // sequencer
   skt_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .req     (req),
      .rsp     (rsp),
      .ram_req (ram_req),
      .rd_data (rd_data)
   );

   // key storage
   skt_key_ram u_key_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (rd_data)
   );

endmodule

`default_nettype wire
